### rtl/suhf_pkg.sv
// ----------------------------------------------------------------------------
// suhf_pkg
// Shared types and constants for the cooked-capture IPv4/UDP header filter.
// ----------------------------------------------------------------------------
package suhf_pkg;

  // width of byte counts and lengths
  localparam int LENGTH_BITS = 16;

  typedef logic [LENGTH_BITS-1:0] len_t;

  localparam len_t COUNT_MAX = {LENGTH_BITS{1'b1}};

  // header geometry
  localparam int LINK_HDR   = 16;
  localparam int IP_MIN_HDR = 20;
  localparam int UDP_HDR    = 8;

  // fixed capture positions within the frame
  localparam len_t POS_PROTO_HI = len_t'(14);
  localparam len_t POS_PROTO_LO = len_t'(15);
  localparam len_t POS_IHL      = len_t'(16);
  localparam len_t POS_IP_PROTO = len_t'(25);

  localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
  localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;

  // verdict codes, in check order
  typedef enum logic [3:0] {
    REJ_OK          = 4'd0,
    REJ_TRUNCATED   = 4'd1,
    REJ_SHORT       = 4'd2,
    REJ_NOT_IPV4    = 4'd3,
    REJ_NOT_UDP     = 4'd4,
    REJ_BAD_IHL     = 4'd5,
    REJ_NO_UDP_HDR  = 4'd6,
    REJ_BAD_UDP_LEN = 4'd7,
    REJ_SHORT_UDP   = 4'd8,
    REJ_PORT        = 4'd9
  } reject_t;

  // one frame byte as held in the input register
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        end_of_frame;
    logic [15:0] wire_length;
  } in_item_t;

  // one verdict
  typedef struct packed {
    logic        accepted;
    logic [3:0]  reject_code;
    logic [6:0]  payload_offset;
    logic [15:0] payload_length;
  } verdict_t;

endpackage

### rtl/suhf_if.sv
// ----------------------------------------------------------------------------
// suhf channels
// Valid/ready channels for frame bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface suhf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        end_of_frame;
  logic [15:0] wire_length;

  modport source (output valid, frame_byte, end_of_frame, wire_length, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, wire_length, output ready);
endinterface

interface suhf_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  reject_code;
  logic [6:0]  payload_offset;
  logic [15:0] payload_length;

  modport source (output valid, accepted, reject_code, payload_offset, payload_length,
                  input ready);
  modport sink   (input valid, accepted, reject_code, payload_offset, payload_length,
                  output ready);
endinterface

### rtl/suhf_in_reg.sv
// ----------------------------------------------------------------------------
// suhf_in_reg
// Input register: holds one frame byte until the parser consumes it.
// ----------------------------------------------------------------------------
module suhf_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  suhf_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               held_valid,
  output suhf_pkg::in_item_t held_item
);

  logic held_valid_next;

  // take a new word when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_comb begin
    held_valid_next = held_valid;
    if (in_ready) begin
      held_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

### rtl/suhf_parse.sv
// ----------------------------------------------------------------------------
// suhf_parse
// Frame state: captures header fields byte by byte and forms the verdict.
// ----------------------------------------------------------------------------
module suhf_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  suhf_pkg::in_item_t item,
  input  logic [15:0]        source_port,
  output suhf_pkg::verdict_t verdict
);

  suhf_pkg::len_t byte_count, byte_count_next;
  suhf_pkg::len_t frame_wire_length, frame_wire_length_next;
  logic [15:0]    link_protocol, link_protocol_next;
  logic [3:0]     ip_header_words, ip_header_words_next;
  logic [7:0]     ip_protocol, ip_protocol_next;
  logic [15:0]    udp_source, udp_source_next;
  logic [15:0]    udp_length, udp_length_next;

  logic [5:0]             ihl_bytes;
  suhf_pkg::len_t         udp_base;
  logic                   counting;
  logic [6:0]             udp_end;
  logic [16:0]            needed_len;
  suhf_pkg::reject_t      code;

  assign counting  = byte_count != suhf_pkg::COUNT_MAX;

  // header length nibble, taken from this byte when it sits at the ihl position
  assign ip_header_words_next = (counting && byte_count == suhf_pkg::POS_IHL) ?
                                item.frame_byte[3:0] : ip_header_words;

  assign ihl_bytes = {ip_header_words_next, 2'b00};
  assign udp_base  = suhf_pkg::len_t'(suhf_pkg::LINK_HDR) + suhf_pkg::len_t'(ihl_bytes);

  // field capture for the current byte position
  always_comb begin
    frame_wire_length_next = frame_wire_length;
    link_protocol_next     = link_protocol;
    ip_protocol_next       = ip_protocol;
    udp_source_next        = udp_source;
    udp_length_next        = udp_length;
    byte_count_next        = byte_count;
    if (byte_count == '0) begin
      frame_wire_length_next = suhf_pkg::len_t'(item.wire_length);
    end
    if (counting) begin
      byte_count_next = byte_count + suhf_pkg::len_t'(1);
      if (byte_count == suhf_pkg::POS_PROTO_HI) link_protocol_next[15:8] = item.frame_byte;
      if (byte_count == suhf_pkg::POS_PROTO_LO) link_protocol_next[7:0]  = item.frame_byte;
      if (byte_count == suhf_pkg::POS_IP_PROTO) ip_protocol_next = item.frame_byte;
      // udp positions follow the header length, including one set by this byte
      if (byte_count == udp_base) udp_source_next[15:8] = item.frame_byte;
      if (byte_count == udp_base + suhf_pkg::len_t'(1)) udp_source_next[7:0] = item.frame_byte;
      if (byte_count == udp_base + suhf_pkg::len_t'(4)) udp_length_next[15:8] = item.frame_byte;
      if (byte_count == udp_base + suhf_pkg::len_t'(5)) udp_length_next[7:0]  = item.frame_byte;
    end
  end

  // verdict checks, first failure wins
  assign udp_end    = 7'(suhf_pkg::LINK_HDR + suhf_pkg::UDP_HDR) + 7'(ihl_bytes);
  assign needed_len = 17'(suhf_pkg::LINK_HDR) + 17'(ihl_bytes) + {1'b0, udp_length_next};

  always_comb begin
    priority if (frame_wire_length_next != byte_count_next) begin
      code = suhf_pkg::REJ_TRUNCATED;
    end else if (frame_wire_length_next <
                 suhf_pkg::len_t'(suhf_pkg::LINK_HDR + suhf_pkg::IP_MIN_HDR)) begin
      code = suhf_pkg::REJ_SHORT;
    end else if (link_protocol_next != suhf_pkg::IPV4_ETHERTYPE) begin
      code = suhf_pkg::REJ_NOT_IPV4;
    end else if (ip_protocol_next != suhf_pkg::UDP_PROTOCOL) begin
      code = suhf_pkg::REJ_NOT_UDP;
    end else if (ihl_bytes < 6'(suhf_pkg::IP_MIN_HDR)) begin
      code = suhf_pkg::REJ_BAD_IHL;
    end else if (frame_wire_length_next < suhf_pkg::len_t'(udp_end)) begin
      code = suhf_pkg::REJ_NO_UDP_HDR;
    end else if (udp_length_next < 16'(suhf_pkg::UDP_HDR)) begin
      code = suhf_pkg::REJ_BAD_UDP_LEN;
    end else if ({1'b0, frame_wire_length_next} < needed_len) begin
      code = suhf_pkg::REJ_SHORT_UDP;
    end else if (udp_source_next != source_port) begin
      code = suhf_pkg::REJ_PORT;
    end else begin
      code = suhf_pkg::REJ_OK;
    end
  end

  // result fields
  always_comb begin
    verdict.accepted       = code == suhf_pkg::REJ_OK;
    verdict.reject_code    = code;
    verdict.payload_offset = '0;
    verdict.payload_length = '0;
    if (code == suhf_pkg::REJ_OK) begin
      verdict.payload_offset = udp_end;
      verdict.payload_length = udp_length_next - 16'(suhf_pkg::UDP_HDR);
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_frame)) begin
      byte_count        <= '0;
      frame_wire_length <= '0;
      link_protocol     <= '0;
      ip_header_words   <= '0;
      ip_protocol       <= '0;
      udp_source        <= '0;
      udp_length        <= '0;
    end else if (step) begin
      byte_count        <= byte_count_next;
      frame_wire_length <= frame_wire_length_next;
      link_protocol     <= link_protocol_next;
      ip_header_words   <= ip_header_words_next;
      ip_protocol       <= ip_protocol_next;
      udp_source        <= udp_source_next;
      udp_length        <= udp_length_next;
    end
  end

endmodule

### rtl/suhf_out_reg.sv
// ----------------------------------------------------------------------------
// suhf_out_reg
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module suhf_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  suhf_pkg::verdict_t verdict,
  output logic               room,
  suhf_out_if.source         out
);

  logic               res_valid, res_valid_next;
  suhf_pkg::verdict_t res;

  // free when empty or being drained this cycle
  assign room = !res_valid || out.ready;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (out.ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= verdict;
    end
  end

  // drive the channel
  assign out.valid          = res_valid;
  assign out.accepted       = res.accepted;
  assign out.reject_code    = res.reject_code;
  assign out.payload_offset = res.payload_offset;
  assign out.payload_length = res.payload_length;

endmodule

### rtl/sll_ipv4_udp_header_filter.sv
// ----------------------------------------------------------------------------
// sll_ipv4_udp_header_filter
// Checks a Linux cooked-capture frame for an IPv4/UDP header from one port.
// ----------------------------------------------------------------------------
// Usage:
//   frame   : frame bytes, one word per byte, link header first. end_of_frame
//             marks the final captured byte; wire_length is taken from the
//             first byte of each frame.
//   verdict : one word per frame, produced for the end_of_frame byte only.
//   cfg_wr_en / cfg_wr_data : write the required UDP source port while idle.
// Throughput is one byte per cycle while the result register has room for
// each end_of_frame byte, set by the single pass through the frame-state
// update and verdict compare. Once its last byte is in the input register,
// a verdict passes through the parse logic into the result register.
// Reset clears the frame state, the source port and both registers.
// While the receiver stalls, the held verdict stays put; bytes keep flowing
// until the next end_of_frame byte needs the result register.
// ----------------------------------------------------------------------------
module sll_ipv4_udp_header_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  suhf_in_if.sink     frame,
  suhf_out_if.source  verdict
);

  logic [15:0]        source_port;
  suhf_pkg::in_item_t in_item;
  suhf_pkg::in_item_t held_item;
  logic               held_valid;
  logic               advance;
  logic               room;
  suhf_pkg::verdict_t result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_port <= '0;
    end else if (cfg_wr_en) begin
      source_port <= cfg_wr_data;
    end
  end

  assign in_item.frame_byte   = frame.frame_byte;
  assign in_item.end_of_frame = frame.end_of_frame;
  assign in_item.wire_length  = frame.wire_length;

  // a held byte moves on unless it needs a full result register
  assign advance = held_valid && (!held_item.end_of_frame || room);

  suhf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (frame.valid),
    .in_ready   (frame.ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  suhf_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (held_item),
    .source_port (source_port),
    .verdict     (result)
  );

  suhf_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && held_item.end_of_frame),
    .verdict (result),
    .room    (room),
    .out     (verdict)
  );

endmodule
